### sv/mpsd_pkg.sv
// Shared types, constants and the Morse trie table for the pixel stream decoder.
package mpsd_pkg;

  localparam int unsigned MaxChars = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [6:0] NodeRoot    = 7'd0;
  localparam logic [6:0] CharNewline = 7'd10;
  localparam logic [6:0] CaseOffset  = 7'd32;

  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [CntW-1:0]          cnt;
    logic [6:0]               next_node;
  } step_t;

  // Child of a trie node for one symbol (0 dot, 1 dash); the root code means no child.
  function automatic logic [6:0] trie_child(logic [6:0] node, logic sym);
    logic [6:0] dot;
    logic [6:0] dash;
    dot  = NodeRoot;
    dash = NodeRoot;
    case (node)
      NodeRoot: begin dot = 7'("E"); dash = 7'("T"); end
      7'("A"):  begin dot = 7'("R"); dash = 7'("W"); end
      7'("B"):  begin dot = 7'("6"); end
      7'("D"):  begin dot = 7'("B"); dash = 7'("X"); end
      7'("E"):  begin dot = 7'("I"); dash = 7'("A"); end
      7'("G"):  begin dot = 7'("Z"); dash = 7'("Q"); end
      7'("H"):  begin dot = 7'("5"); dash = 7'("4"); end
      7'("I"):  begin dot = 7'("S"); dash = 7'("U"); end
      7'("J"):  begin dash = 7'("1"); end
      7'("K"):  begin dot = 7'("C"); dash = 7'("Y"); end
      7'("M"):  begin dot = 7'("G"); dash = 7'("O"); end
      7'("N"):  begin dot = 7'("D"); dash = 7'("K"); end
      7'("O"):  begin dot = 7'("~"); dash = 7'("o"); end
      7'("R"):  begin dot = 7'("L"); end
      7'("S"):  begin dot = 7'("H"); dash = 7'("V"); end
      7'("T"):  begin dot = 7'("N"); dash = 7'("M"); end
      7'("U"):  begin dot = 7'("F"); dash = 7'("u"); end
      7'("V"):  begin dash = 7'("3"); end
      7'("W"):  begin dot = 7'("P"); dash = 7'("J"); end
      7'("Z"):  begin dot = 7'("7"); end
      7'("o"):  begin dot = 7'("9"); dash = 7'("0"); end
      7'("u"):  begin dash = 7'("2"); end
      7'("~"):  begin dot = 7'("8"); end
      default: begin
        dot  = NodeRoot;
        dash = NodeRoot;
      end
    endcase
    return sym ? dash : dot;
  endfunction

endpackage

### sv/morse_pixel_stream_decoder.sv
// An accepted item goes through the input register and then the result register.
// Throughput: one item per cycle while each item yields at most one character and the
// output is ready; an item with several characters holds the result register until all
// are out. Rate is set by the single result register, one character per ready cycle.
// Reset (rst_ni low, asynchronous) empties both registers, returns the trie
// walk to the root and clears the reverse-video setting.
module morse_pixel_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_high_i,
  input  logic       last_in_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] char_code_o,
  output logic       last_of_run_o
);

  // Input register: only the symbol bit and the row-end flag are kept.
  logic       in_vld_q, in_vld_d;
  logic       in_bit_q;
  logic       in_last_q;
  logic       rev_q;
  logic [6:0] node_q, node_d;
  logic       buf_free;
  logic       advance;
  logic       accept;

  mpsd_pkg::step_t step;

  // An item moves on to the result register whenever that register is empty
  // or is giving up its final character in this cycle.
  assign advance    = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // The trie walk sees the symbol after the reverse-video swap; configuration is only to
  // be changed while the block is idle (the block does not enforce this) to make it safe.
  mpsd_step u_step (
    .node_i (node_q),
    .sym_i  (in_bit_q ^ rev_q),
    .last_i (in_last_q),
    .step_o (step)
  );

  mpsd_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .step_i        (step),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .last_of_run_o (last_of_run_o)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // The current node only moves when its item is handed on, so items are
  // walked strictly in order.
  assign node_d = advance ? step.next_node : node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      node_q   <= mpsd_pkg::NodeRoot;
      rev_q    <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      node_q   <= node_d;
      if (cfg_we_i) begin
        rev_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_bit_q  <= red_high_i[7];
      in_last_q <= last_in_row_i;
    end
  end

  a_row_end_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (node_q == mpsd_pkg::NodeRoot))
    else $error("trie walk not back at the root after a row end");

  a_row_end_newline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |-> (step.cnt != '0))
    else $error("row end produced no characters");

  a_node_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(node_q))
    else $error("trie node moved without an item being handed on");

endmodule

### sv/mpsd_step.sv
// Combinational trie step and row-end flush for one symbol.
module mpsd_step (
  input  logic           [6:0] node_i,
  input  logic                 sym_i,
  input  logic                 last_i,
  output mpsd_pkg::step_t      step_o
);

  logic [6:0]                                  child;
  logic [6:0]                                  emit;
  logic [6:0]                                  restart;
  logic [6:0]                                  node_n;
  logic [mpsd_pkg::CntW-1:0]                   cnt;
  logic [mpsd_pkg::MaxChars-1:0][6:0]          chars;

  always_comb begin
    child   = mpsd_pkg::trie_child(node_i, sym_i);
    chars   = '0;
    cnt     = '0;
    node_n  = child;
    emit    = node_i;
    restart = mpsd_pkg::NodeRoot;

    // Helper nodes emit their first letter and resume from their second.
    if (node_i == 7'("~")) begin
      emit    = 7'("O");
      restart = 7'("E");
    end else if (node_i > 7'("Z")) begin
      emit    = node_i - mpsd_pkg::CaseOffset;
      restart = 7'("T");
    end

    if (child == mpsd_pkg::NodeRoot) begin
      chars[0] = emit;
      cnt      = 3'd1;
      node_n   = mpsd_pkg::trie_child(restart, sym_i);
    end

    if (last_i) begin
      if (node_n == 7'("~")) begin
        chars[cnt[1:0]] = 7'("M");
        cnt             = cnt + 3'd1;
        chars[cnt[1:0]] = 7'("N");
        cnt             = cnt + 3'd1;
      end else if (node_n > 7'("Z")) begin
        chars[cnt[1:0]] = node_n - mpsd_pkg::CaseOffset;
        cnt             = cnt + 3'd1;
        chars[cnt[1:0]] = 7'("T");
        cnt             = cnt + 3'd1;
      end else if (node_n != mpsd_pkg::NodeRoot) begin
        chars[cnt[1:0]] = node_n;
        cnt             = cnt + 3'd1;
      end
      chars[cnt[1:0]] = mpsd_pkg::CharNewline;
      cnt             = cnt + 3'd1;
      node_n          = mpsd_pkg::NodeRoot;
    end

    step_o.chars     = chars;
    step_o.cnt       = cnt;
    step_o.next_node = node_n;
  end

endmodule

### sv/mpsd_out_buf.sv
// Result register that hands out the characters of one item one per cycle while ready.
module mpsd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mpsd_pkg::step_t      step_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic           [6:0] char_code_o,
  output logic                 last_of_run_o
);

  logic [mpsd_pkg::MaxChars-1:0][6:0] chars_q, chars_d;
  logic [mpsd_pkg::CntW-1:0]          n_q, n_d;
  logic                               pop;

  assign out_valid_o   = (n_q != '0);
  assign char_code_o   = chars_q[0];
  assign last_of_run_o = (n_q == 3'd1);
  assign pop           = out_valid_o && out_ready_i;
  assign free_o        = (n_q == '0) || ((n_q == 3'd1) && out_ready_i);

  always_comb begin
    chars_d = chars_q;
    n_d     = n_q;
    if (load_i) begin
      chars_d = step_i.chars;
      n_d     = step_i.cnt;
    end else if (pop) begin
      chars_d = {7'd0, chars_q[mpsd_pkg::MaxChars-1:1]};
      n_d     = n_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else begin
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 3'd4)
    else $error("result count above four");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register loaded while still busy");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && !load_i) |=> ($stable(chars_q) && $stable(n_q)))
    else $error("stalled result changed");

endmodule
